// ===== rtl/core/direct_mapped_cache_write_through_core_assert.svh =====
// Assertion macros for the write-through cache core checker.
// Needs nothing else; included by the checker file only.
`ifndef DIRECT_MAPPED_CACHE_WRITE_THROUGH_CORE_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_WRITE_THROUGH_CORE_ASSERT_SVH

// Property checked from the next cycle on, disabled while reset is low.
`define DMCWT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache core assertion failed");

// Property checked from the next cycle on, active during reset as well.
`define DMCWT_ASSERT_NEXT_NR(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cache core assertion failed during reset");

`endif

// ===== rtl/core/dmcwt_pkg.sv =====
// Shared constants, command codes and control structs of the cache core.
// Depends on nothing; imported by every module of the core.
package dmcwt_pkg;

  localparam int MEM_WORDS   = 65536;
  localparam int CACHE_WORDS = 1024;
  localparam int BLOCK_WORDS = 16;
  localparam int NUM_LINES   = CACHE_WORDS / BLOCK_WORDS;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 32;
  localparam int MEM_AW   = $clog2(MEM_WORDS);
  localparam int WORD_W   = $clog2(BLOCK_WORDS);
  localparam int LINE_W   = $clog2(NUM_LINES);
  localparam int CACHE_AW = WORD_W + LINE_W;
  localparam int TAG_W    = MEM_AW - CACHE_AW;
  localparam int FILL_W   = WORD_W + 1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic compare;
    logic fill_step;
    logic load_out;
  } dmcwt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic hit;
    logic fill_last;
    logic out_free;
  } dmcwt_stat_t;

endpackage

// ===== rtl/core/dmcwt_ctrl.sv =====
// Controller state machine of the cache core.
// Depends on dmcwt_pkg; drives the datapath through dmcwt_cmd_t.
module dmcwt_ctrl
  import dmcwt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  dmcwt_stat_t stat,
  output dmcwt_cmd_t  cmd
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_FILL = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        if (!stat.is_write && !stat.hit) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/dmcwt_dp.sv =====
// Datapath of the cache core: main memory, tag and data stores, counters
// and the output register. Depends on dmcwt_pkg; commanded by dmcwt_ctrl.
module dmcwt_dp
  import dmcwt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dmcwt_cmd_t               cmd,
  output dmcwt_stat_t              stat,
  input  logic                     in_cmd,
  input  logic        [ADDR_W-1:0] in_address,
  input  logic signed [DATA_W-1:0] in_write_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_data_value,
  output logic        [TAG_W-1:0]  out_tag_out,
  output logic        [LINE_W-1:0] out_line_out,
  output logic        [WORD_W-1:0] out_word_out
);

  logic [DATA_W-1:0] mem [MEM_WORDS];
  logic [DATA_W-1:0] lmem [NUM_LINES * BLOCK_WORDS];
  logic [TAG_W-1:0]  tmem [NUM_LINES];

  logic              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] wdata_r;

  logic [MEM_AW-1:0] clr_cnt_r;
  logic [FILL_W-1:0] fill_cnt_r;
  logic              fill_wv_r;
  logic [WORD_W-1:0] fill_wi_r;
  logic [NUM_LINES-1:0] valid_r;

  logic [DATA_W-1:0] mem_rd_r;
  logic [DATA_W-1:0] lrd_r;
  logic [TAG_W-1:0]  tag_rd_r;

  logic              res_hit_r;
  logic [DATA_W-1:0] res_data_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_data_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [LINE_W-1:0] out_line_r;
  logic [WORD_W-1:0] out_word_r;

  logic [TAG_W-1:0]    tag;
  logic [LINE_W-1:0]   line;
  logic [WORD_W-1:0]   word;
  logic                is_write;
  logic                hit;
  logic                fill_last;
  logic [MEM_AW-1:0]   mem_ra;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_wa;
  logic [DATA_W-1:0]   mem_wd;
  logic                lmem_we;
  logic [CACHE_AW-1:0] lmem_wa;
  logic [DATA_W-1:0]   lmem_wd;

  assign tag       = addr_r[MEM_AW-1:CACHE_AW];
  assign line      = addr_r[CACHE_AW-1:WORD_W];
  assign word      = addr_r[WORD_W-1:0];
  assign is_write  = (cmd_r == CMD_WRITE);
  assign hit       = valid_r[line] && (tag_rd_r == tag);
  assign fill_last = (fill_cnt_r == FILL_W'(BLOCK_WORDS));
  assign mem_ra    = {addr_r[MEM_AW-1:WORD_W], fill_cnt_r[WORD_W-1:0]};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r[MEM_AW-1:0];
    mem_wd = wdata_r;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = DATA_W'(MEM_WORDS) - DATA_W'(clr_cnt_r);
    end else if (cmd.compare && is_write) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    lmem_we = 1'b0;
    lmem_wa = {line, word};
    lmem_wd = wdata_r;
    if (fill_wv_r) begin
      lmem_we = 1'b1;
      lmem_wa = {line, fill_wi_r};
      lmem_wd = mem_rd_r;
    end else if (cmd.compare && is_write && hit) begin
      lmem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (lmem_we) begin
      lmem[lmem_wa] <= lmem_wd;
    end
    lrd_r <= lmem[{line, word}];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step && fill_last) begin
      tmem[line] <= tag;
    end
    tag_rd_r <= tmem[line];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
    if (cmd.compare) begin
      res_hit_r  <= hit;
      res_data_r <= is_write ? wdata_r : lrd_r;
    end else if (fill_wv_r && (fill_wi_r == word)) begin
      res_data_r <= mem_rd_r;
    end
    if (cmd.load_out) begin
      out_hit_r  <= res_hit_r;
      out_data_r <= res_data_r;
      out_tag_r  <= tag;
      out_line_r <= line;
      out_word_r <= word;
    end
    fill_wi_r <= fill_cnt_r[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      fill_cnt_r  <= '0;
      fill_wv_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      end
      if (cmd.capture) begin
        fill_cnt_r <= '0;
      end else if (cmd.fill_step) begin
        fill_cnt_r <= fill_cnt_r + FILL_W'(1);
      end
      fill_wv_r <= cmd.fill_step && !fill_last;
      if (cmd.fill_step && fill_last) begin
        valid_r[line] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clr_last  = (clr_cnt_r == MEM_AW'(MEM_WORDS - 1));
  assign stat.is_write  = is_write;
  assign stat.hit       = hit;
  assign stat.fill_last = fill_last;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_data_value = out_data_r;
  assign out_tag_out    = out_tag_r;
  assign out_line_out   = out_line_r;
  assign out_word_out   = out_word_r;

endmodule

// ===== rtl/core/direct_mapped_cache_write_through_core.sv =====
// Direct-mapped write-through cache with its main memory.
// Input channel (in_*): one read or write access per transfer.
// Result channel (out_*): exactly one result per access, in order, giving the
// hit flag, the data word and the tag, line and word fields of the address.
// Only one access is in flight at a time. A write or a read hit passes the
// look-up, compare and done states into the output register, and the next
// access can be taken in the same cycle as its result appears. A read miss
// refills the whole 16-word line from main memory, one word per cycle through
// the memory's single read port, in the fill state before the done state.
// After reset main memory is initialized in one pass over its 65536 words, one
// word per cycle; in_ready stays low until it is done. All lines start invalid.
// The result sits in an output register: a new access is taken while it waits,
// but the next result is held back until the receiver takes the current one.
// Depends on dmcwt_pkg, dmcwt_ctrl and dmcwt_dp.
module direct_mapped_cache_write_through_core
  import dmcwt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic        [ADDR_W-1:0] in_address,
  input  logic signed [DATA_W-1:0] in_write_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_data_value,
  output logic        [TAG_W-1:0]  out_tag_out,
  output logic        [LINE_W-1:0] out_line_out,
  output logic        [WORD_W-1:0] out_word_out
);

  dmcwt_cmd_t  cmd;
  dmcwt_stat_t stat;

  dmcwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmcwt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_data_value (out_data_value),
    .out_tag_out    (out_tag_out),
    .out_line_out   (out_line_out),
    .out_word_out   (out_word_out)
  );

endmodule

// ===== rtl/core/dmcwt_checker.sv =====
// Port-level checker of the cache core and its bind to the top level.
// Depends on dmcwt_pkg and direct_mapped_cache_write_through_core_assert.svh.
`include "direct_mapped_cache_write_through_core_assert.svh"

module dmcwt_checker
  import dmcwt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic [DATA_W-1:0] out_data_value
);

  `DMCWT_ASSERT_NEXT_NR(a_reset_blocks_input, clk, !rst_n, !in_ready)
  `DMCWT_ASSERT_NEXT(a_access_busy, clk, rst_n, in_valid && in_ready, !in_ready ##1 !in_ready ##1 !in_ready)
  `DMCWT_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data_value) && $stable(out_hit))

endmodule

bind direct_mapped_cache_write_through_core dmcwt_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hit        (out_hit),
  .out_data_value (out_data_value)
);

// ===== test/cache_access_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the write-through cache core: it keeps its own main memory and
// cache lines, predicts every accepted access and compares each result transfer.
// Depends on dmcwt_pkg for the widths, the sizes and the command codes.
module cache_access_checker
  import dmcwt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_cmd,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_hit,
  input  logic [DATA_W-1:0] out_data_value,
  input  logic [TAG_W-1:0]  out_tag_out,
  input  logic [LINE_W-1:0] out_line_out,
  input  logic [WORD_W-1:0] out_word_out,
  output int                mismatches,
  output int                outstanding,
  output int                read_hits,
  output int                read_misses,
  output int                writes,
  output int                write_hits
);

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
    logic [WORD_W-1:0] word;
  } access_result_t;

  logic [DATA_W-1:0] main_mem [MEM_WORDS];
  logic              line_loaded [NUM_LINES];
  logic [TAG_W-1:0]  line_tags [NUM_LINES];
  logic [DATA_W-1:0] line_data [NUM_LINES*BLOCK_WORDS];

  access_result_t expected_results [$];
  int fail_total;
  int n_read_hits;
  int n_read_misses;
  int n_writes;
  int n_write_hits;

  function automatic access_result_t predict_access(input logic cmd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] wdata);
    access_result_t res;
    int unsigned slot;
    int unsigned base;
    int unsigned i;
    res.tag  = addr[MEM_AW-1:CACHE_AW];
    res.line = addr[CACHE_AW-1:WORD_W];
    res.word = addr[WORD_W-1:0];
    res.hit  = line_loaded[res.line] && (line_tags[res.line] == res.tag);
    slot = res.line * BLOCK_WORDS;
    base = addr - res.word;
    if (cmd == CMD_WRITE) begin
      main_mem[addr] = wdata;
      if (res.hit) begin
        line_data[slot + res.word] = wdata;
        n_write_hits++;
      end
      res.data = wdata;
      n_writes++;
    end else if (res.hit) begin
      res.data = line_data[slot + res.word];
      n_read_hits++;
    end else begin
      for (i = 0; i < BLOCK_WORDS; i++) begin
        line_data[slot + i] = main_mem[(base + i) % MEM_WORDS];
      end
      line_loaded[res.line] = 1'b1;
      line_tags[res.line] = res.tag;
      res.data = line_data[slot + res.word];
      n_read_misses++;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    access_result_t exp_r;
    if (!rst_n) begin
      for (int unsigned k = 0; k < MEM_WORDS; k++) begin
        main_mem[k] = MEM_WORDS - k;
      end
      for (int unsigned k = 0; k < NUM_LINES; k++) begin
        line_loaded[k] = 1'b0;
        line_tags[k] = '0;
      end
      expected_results.delete();
      fail_total = 0;
      n_read_hits = 0;
      n_read_misses = 0;
      n_writes = 0;
      n_write_hits = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_access(in_cmd, in_address, in_write_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with no access waiting, expected none, actual %0h",
                   $time, out_data_value);
          fail_total++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("hit", exp_r.hit, out_hit);
          check_field("data_value", exp_r.data, out_data_value);
          check_field("tag_out", exp_r.tag, out_tag_out);
          check_field("line_out", exp_r.line, out_line_out);
          check_field("word_out", exp_r.word, out_word_out);
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_results.size();
    read_hits   <= n_read_hits;
    read_misses <= n_read_misses;
    writes      <= n_writes;
    write_hits  <= n_write_hits;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the write-through cache core regression: clock, reset, access stimulus and
// result-channel back-pressure. Depends on dmcwt_pkg, the core and cache_access_checker.
module testbench;
  import dmcwt_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_cmd;
  logic        [ADDR_W-1:0] in_address;
  logic signed [DATA_W-1:0] in_write_data;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_data_value;
  logic        [TAG_W-1:0]  out_tag_out;
  logic        [LINE_W-1:0] out_line_out;
  logic        [WORD_W-1:0] out_word_out;

  int mismatches;
  int outstanding;
  int read_hits;
  int read_misses;
  int writes;
  int write_hits;
  bit send_burst;

  direct_mapped_cache_write_through_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_data_value(out_data_value),
    .out_tag_out   (out_tag_out),
    .out_line_out  (out_line_out),
    .out_word_out  (out_word_out)
  );

  cache_access_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_data_value(out_data_value),
    .out_tag_out   (out_tag_out),
    .out_line_out  (out_line_out),
    .out_word_out  (out_word_out),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .read_hits     (read_hits),
    .read_misses   (read_misses),
    .writes        (writes),
    .write_hits    (write_hits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("direct_mapped_cache_write_through_core regression: fail");
    $finish;
  end

  task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_address    <= addr;
    in_write_data <= wdata;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int gap;
    int taken;
    bit burst;
    out_ready <= 1'b0;
    taken = 0;
    burst = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 8);
      if (taken == 150) gap = 400;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int n;
    int pick;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] last_addr;
    logic [DATA_W-1:0] wdata;
    logic [TAG_W-1:0]  hot_a;
    logic [TAG_W-1:0]  hot_b;
    logic [TAG_W-1:0]  tg;
    logic [LINE_W-1:0] ln;
    logic [WORD_W-1:0] wd;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_READ;
    in_address    <= '0;
    in_write_data <= '0;
    send_burst = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // A fill, hits on it, a write hit, write misses that do not allocate, and evictions.
    send_access(CMD_READ,  16'h0000, '0);
    send_access(CMD_READ,  16'h0000, '0);
    send_access(CMD_READ,  16'h000F, '0);
    send_access(CMD_WRITE, 16'h0005, 32'h7FFF_FFFF);
    send_access(CMD_READ,  16'h0005, '0);
    send_access(CMD_WRITE, 16'hFFFF, 32'h8000_0000);
    send_access(CMD_WRITE, 16'hFFFF, 32'h0000_0001);
    send_access(CMD_READ,  16'hFFFF, 32'hFFFF_FFFF);
    send_access(CMD_READ,  16'hFFF0, '0);
    send_access(CMD_READ,  16'hFC00, '0);
    send_access(CMD_READ,  16'h0005, '0);
    send_access(CMD_WRITE, 16'h0005, 32'hFFFF_FFFF);
    send_access(CMD_READ,  16'h0005, '0);
    send_access(CMD_WRITE, 16'h8421, 32'h0000_0000);
    send_access(CMD_READ,  16'h8421, '0);
    send_access(CMD_READ,  16'h7BDE, '0);
    send_access(CMD_WRITE, 16'h7BDE, 32'h5A5A_5A5A);
    send_access(CMD_READ,  16'h7BDE, '0);

    last_addr = 16'h7BDE;
    hot_a = '0;
    hot_b = '0;
    for (n = 0; n < 1232; n++) begin
      if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n % 256 == 0) begin
        hot_a = TAG_W'($urandom_range(0, 63));
        hot_b = TAG_W'($urandom_range(0, 63));
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        tg = $urandom_range(0, 1) ? hot_a : hot_b;
        ln = LINE_W'($urandom_range(0, 7));
        wd = WORD_W'($urandom_range(0, 15));
        addr = {tg, ln, wd};
      end else if (pick < 65) begin
        addr = last_addr + 1'b1;
      end else if (pick < 75) begin
        addr = last_addr;
      end else begin
        addr = ADDR_W'($urandom);
      end
      cmd = ($urandom_range(0, 99) < 35) ? CMD_WRITE : CMD_READ;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: wdata = 32'h0000_0000;
          1: wdata = 32'hFFFF_FFFF;
          2: wdata = 32'h7FFF_FFFF;
          default: wdata = 32'h8000_0000;
        endcase
      end else begin
        wdata = $urandom;
      end
      send_access(cmd, addr, wdata);
      last_addr = addr;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);

    $display("Covered %0d accesses: %0d read hits, %0d read misses, %0d writes %s",
             read_hits + read_misses + writes, read_hits, read_misses, writes,
             $sformatf("(%0d on cached lines).", write_hits));
    $display("Both channels idled at random; the result side held off for 400 cycles once.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("direct_mapped_cache_write_through_core regression: pass");
    end else begin
      $display("direct_mapped_cache_write_through_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dmcwt_pkg.sv
rtl/core/dmcwt_ctrl.sv
rtl/core/dmcwt_dp.sv
rtl/core/direct_mapped_cache_write_through_core.sv
rtl/core/dmcwt_checker.sv
test/cache_access_checker.sv
test/testbench.sv
